>>> src/mi3_pkg.sv
// Shared types, widths and cofactor index table for the 3x3 matrix inverse.
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;

  localparam int unsigned DW    = 32;            // entry width
  localparam int unsigned FB    = 16;            // fraction bits
  localparam int unsigned PW    = 2 * DW;        // one entry product
  localparam int unsigned CW    = 2 * DW + 1;    // signed cofactor
  localparam int unsigned CMW   = 2 * DW;        // cofactor magnitude
  localparam int unsigned PLW   = 2 * DW + 1;    // split product for determinant
  localparam int unsigned DTW   = 3 * DW + 3;    // signed determinant
  localparam int unsigned QB    = DW + 2;        // quotient bits below overflow bit
  localparam int unsigned RW    = DTW + QB;      // divider remainder width
  localparam int unsigned SW    = $clog2(QB + 1);
  localparam int unsigned QDEPTH = 4;            // front to back queue depth
  localparam int unsigned QAW   = $clog2(QDEPTH);
  localparam int unsigned QCW   = $clog2(QDEPTH + 1);
  localparam int unsigned NLANE = 9;

  // adjugate entry i = m[a]*m[b] - m[c]*m[d], entries indexed row*3+col
  localparam int unsigned COF_IDX [NLANE][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic signed [DW-1:0] m_00;
    logic signed [DW-1:0] m_01;
    logic signed [DW-1:0] m_02;
    logic signed [DW-1:0] m_10;
    logic signed [DW-1:0] m_11;
    logic signed [DW-1:0] m_12;
    logic signed [DW-1:0] m_20;
    logic signed [DW-1:0] m_21;
    logic signed [DW-1:0] m_22;
  } mi3_in_t;

  typedef struct packed {
    logic signed [DW-1:0] inv_00;
    logic signed [DW-1:0] inv_01;
    logic signed [DW-1:0] inv_02;
    logic signed [DW-1:0] inv_10;
    logic signed [DW-1:0] inv_11;
    logic signed [DW-1:0] inv_12;
    logic signed [DW-1:0] inv_20;
    logic signed [DW-1:0] inv_21;
    logic signed [DW-1:0] inv_22;
    logic                 singular;
  } mi3_out_t;

  // one queued job: adjugate and determinant, both exact
  typedef struct packed {
    logic [NLANE-1:0][CW-1:0] adj;
    logic [DTW-1:0]           det;
  } mi3_job_t;

endpackage
`default_nettype wire

>>> src/mi3_front.sv
// Front pipeline: cofactors and determinant of each accepted matrix.
`timescale 1ns / 1ps
`default_nettype none
module mi3_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire mi3_pkg::mi3_in_t in_data,
  output logic                  job_valid,
  output mi3_pkg::mi3_job_t     job_data
);

  localparam int unsigned DW  = mi3_pkg::DW;
  localparam int unsigned PW  = mi3_pkg::PW;
  localparam int unsigned CW  = mi3_pkg::CW;
  localparam int unsigned PLW = mi3_pkg::PLW;
  localparam int unsigned DTW = mi3_pkg::DTW;
  localparam int unsigned NL  = mi3_pkg::NLANE;

  logic signed [DW-1:0]  mm [9];
  logic [4:0]            v_r;
  logic signed [PW-1:0]  pa_r [NL];
  logic signed [PW-1:0]  pb_r [NL];
  logic signed [DW-1:0]  row1_r [3];
  logic signed [DW-1:0]  row2_r [3];
  logic signed [CW-1:0]  adj2_r [NL];
  logic signed [CW-1:0]  adj3_r [NL];
  logic signed [CW-1:0]  adj4_r [NL];
  logic signed [PLW-1:0] plo_r [3];
  logic signed [PLW-1:0] phi_r [3];
  logic signed [DTW-1:0] term_r [3];
  logic signed [CW-1:0]  adj5_r [NL];
  logic signed [DTW-1:0] det_r;

  assign mm[0] = in_data.m_00;
  assign mm[1] = in_data.m_01;
  assign mm[2] = in_data.m_02;
  assign mm[3] = in_data.m_10;
  assign mm[4] = in_data.m_11;
  assign mm[5] = in_data.m_12;
  assign mm[6] = in_data.m_20;
  assign mm[7] = in_data.m_21;
  assign mm[8] = in_data.m_22;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // stage 1: the eighteen entry products
  always_ff @(posedge clk) begin
    for (int i = 0; i < NL; i++) begin
      pa_r[i] <= PW'(mm[mi3_pkg::COF_IDX[i][0]]) * PW'(mm[mi3_pkg::COF_IDX[i][1]]);
      pb_r[i] <= PW'(mm[mi3_pkg::COF_IDX[i][2]]) * PW'(mm[mi3_pkg::COF_IDX[i][3]]);
    end
    for (int j = 0; j < 3; j++) begin
      row1_r[j] <= mm[j];
    end
  end

  // stage 2: cofactor differences
  always_ff @(posedge clk) begin
    for (int i = 0; i < NL; i++) begin
      adj2_r[i] <= CW'(pa_r[i]) - CW'(pb_r[i]);
    end
    row2_r <= row1_r;
  end

  // stage 3: row 0 entry times its cofactor, split in two halves
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      plo_r[j] <= PLW'($signed({1'b0, adj2_r[3*j][DW-1:0]})) * PLW'(row2_r[j]);
      phi_r[j] <= PLW'($signed(adj2_r[3*j][CW-1:DW])) * PLW'(row2_r[j]);
    end
    adj3_r <= adj2_r;
  end

  // stage 4: rejoin each split product
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      term_r[j] <= (DTW'(phi_r[j]) <<< DW) + DTW'(plo_r[j]);
    end
    adj4_r <= adj3_r;
  end

  // stage 5: sum along row 0
  always_ff @(posedge clk) begin
    det_r  <= term_r[0] + term_r[1] + term_r[2];
    adj5_r <= adj4_r;
  end

  assign job_valid = v_r[4];
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      job_data.adj[i] = adj5_r[i];
    end
    job_data.det = det_r;
  end

endmodule
`default_nettype wire

>>> src/mi3_fifo.sv
// Short job queue between the front pipeline and the divider.
`timescale 1ns / 1ps
`default_nettype none
module mi3_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mi3_pkg::mi3_job_t push_data,
  input  wire logic              pop,
  output logic                   empty,
  output mi3_pkg::mi3_job_t      head
);

  localparam int unsigned QAW = mi3_pkg::QAW;

  mi3_pkg::mi3_job_t     mem_r [mi3_pkg::QDEPTH];
  logic [QAW-1:0]        wp_r, rp_r;
  logic [mi3_pkg::QCW-1:0] cnt_r;

  // store pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  // move pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + mi3_pkg::QCW'(push) - mi3_pkg::QCW'(pop);
    end
  end

  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

endmodule
`default_nettype wire

>>> src/mi3_back.sv
// Back end: nine restoring dividers, rounding, saturation and result word.
`timescale 1ns / 1ps
`default_nettype none
module mi3_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_empty,
  input  wire mi3_pkg::mi3_job_t job_head,
  output logic                   job_pop,
  output logic                   out_valid,
  output mi3_pkg::mi3_out_t      out_data
);

  localparam int unsigned DW  = mi3_pkg::DW;
  localparam int unsigned FB  = mi3_pkg::FB;
  localparam int unsigned CW  = mi3_pkg::CW;
  localparam int unsigned CMW = mi3_pkg::CMW;
  localparam int unsigned DTW = mi3_pkg::DTW;
  localparam int unsigned QB  = mi3_pkg::QB;
  localparam int unsigned RW  = mi3_pkg::RW;
  localparam int unsigned SW  = mi3_pkg::SW;
  localparam int unsigned NL  = mi3_pkg::NLANE;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } bst_t;

  bst_t               st_r, st_nxt;
  logic [SW-1:0]      step_r;
  logic [RW-1:0]      rem_r [NL];
  logic [RW-1:0]      rem_nxt [NL];
  logic [QB:0]        q_r [NL];
  logic [QB:0]        q_nxt [NL];
  logic [NL-1:0]      neg_r;
  logic [RW-1:0]      dsh_r;
  logic               sing_r;
  logic               out_valid_r;
  logic [DW-1:0]      res_nxt [NL];
  logic [DW-1:0]      res_r [NL];
  logic               sing_out_r;
  logic signed [DTW-1:0] det_s;
  logic [DTW-1:0]     dabs;
  logic               last;

  // round half away, saturate, apply sign
  function automatic logic [DW-1:0] finish(input logic [QB:0] q, input logic neg);
    logic [QB:0]   q1;
    logic [QB-1:0] lim;
    logic [QB-1:0] mag;
    logic [QB-1:0] sv;
    q1  = ({1'b0, q[QB-1:0]} + 1'b1) >> 1;
    lim = neg ? (QB'(1) << (DW - 1)) : ((QB'(1) << (DW - 1)) - 1'b1);
    mag = (q[QB] || (q1[QB-1:0] > lim)) ? lim : q1[QB-1:0];
    sv  = neg ? (QB'(0) - mag) : mag;
    return sv[DW-1:0];
  endfunction

  assign job_pop = (st_r == S_IDLE) && !job_empty;
  assign last    = (step_r == '0);
  assign det_s   = $signed(job_head.det);
  assign dabs    = det_s[DTW-1] ? DTW'(-det_s) : DTW'(det_s);

  // one trial subtraction per lane
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      logic [RW:0] diff;
      diff = {1'b0, rem_r[i]} - {1'b0, dsh_r};
      if (!diff[RW]) begin
        rem_nxt[i] = diff[RW-1:0];
        q_nxt[i]   = {q_r[i][QB-1:0], 1'b1};
      end else begin
        rem_nxt[i] = rem_r[i];
        q_nxt[i]   = {q_r[i][QB-1:0], 1'b0};
      end
      res_nxt[i] = sing_r ? '0 : finish(q_nxt[i], neg_r[i]);
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (!job_empty) st_nxt = S_RUN;
      S_RUN:   if (last) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= (st_r == S_RUN) && last;
    end
  end

  // load a job or step the dividers
  always_ff @(posedge clk) begin
    if (job_pop) begin
      for (int i = 0; i < NL; i++) begin
        logic signed [CW-1:0] c;
        c = $signed(job_head.adj[i]);
        neg_r[i] <= c[CW-1] ^ det_s[DTW-1];
        rem_r[i] <= RW'(c[CW-1] ? CMW'(-c) : CMW'(c)) << (2 * FB + 1);
        q_r[i]   <= '0;
      end
      dsh_r  <= RW'(dabs) << QB;
      sing_r <= (job_head.det == '0);
      step_r <= SW'(QB);
    end else if (st_r == S_RUN) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r - 1'b1;
    end
  end

  // capture finished result word
  always_ff @(posedge clk) begin
    if ((st_r == S_RUN) && last) begin
      res_r      <= res_nxt;
      sing_out_r <= sing_r;
    end
  end

  assign out_valid = out_valid_r;
  always_comb begin
    out_data.inv_00   = res_r[0];
    out_data.inv_01   = res_r[1];
    out_data.inv_02   = res_r[2];
    out_data.inv_10   = res_r[3];
    out_data.inv_11   = res_r[4];
    out_data.inv_12   = res_r[5];
    out_data.inv_20   = res_r[6];
    out_data.inv_21   = res_r[7];
    out_data.inv_22   = res_r[8];
    out_data.singular = sing_out_r;
  end

endmodule
`default_nettype wire

>>> src/matrix_inverse_3x3.sv
// Top level: 3x3 matrix inverse by adjugate, Q16.16 in and out.
// Path: the front pipeline stages, the queue, a load of the dividers and 35 divide steps;
// out_valid is registered from the last divide step.
// The nine bit-serial dividers take one quotient bit per cycle and take a new word only when the last is done;
// the front accepts up to 4 words ahead.
// Reset (rst_n low, synchronous) empties the pipeline and the queue.
// out_valid is a single-cycle strobe; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_3x3 (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire mi3_pkg::mi3_in_t in_data,
  output logic                  out_valid,
  output mi3_pkg::mi3_out_t     out_data
);

  localparam int unsigned QCW = mi3_pkg::QCW;

  logic              accept;
  logic              job_valid;
  mi3_pkg::mi3_job_t job_data;
  mi3_pkg::mi3_job_t job_head;
  logic              job_empty;
  logic              job_pop;
  logic [QCW-1:0]    cnt_r;

  assign accept = start && !busy;
  assign busy   = (cnt_r == QCW'(mi3_pkg::QDEPTH));

  // count words held in front and queue so the queue never overflows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + QCW'(accept) - QCW'(job_pop);
    end
  end

  mi3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_data  (job_data)
  );

  mi3_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_valid),
    .push_data (job_data),
    .pop       (job_pop),
    .empty     (job_empty),
    .head      (job_head)
  );

  mi3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_head  (job_head),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(mi3_pkg::QDEPTH))
    else $error("word count above queue depth");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.singular) |-> (out_data.inv_00 == '0 && out_data.inv_22 == '0))
    else $error("singular result not zero");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (cnt_r != '0))
    else $error("job taken with no word counted");

endmodule
`default_nettype wire
